// ===== src/smf_pkg.sv =====
// package: coordinate and payload types shared by the median filter modules
`default_nettype none
package smf_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int WINDOW_DEFAULT = 7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // one scan point on the input channel
    typedef struct packed {
        coord_t x_coord;
        coord_t y_coord;
    } point_t;

    // one result on the output channel
    typedef struct packed {
        coord_t median_x;
        coord_t median_y;
    } result_t;

    // ranking result for the candidate entry, per axis
    typedef struct packed {
        logic   hit_x;
        logic   hit_y;
        coord_t cand_x;
        coord_t cand_y;
    } rank_res_t;

endpackage
`default_nettype wire

// ===== src/smf_window.sv =====
// window storage: shift line holding the last WINDOW points, newest in entry 0
`default_nettype none
module smf_window #(
    parameter int WINDOW = smf_pkg::WINDOW_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            shift_en,
    input  wire smf_pkg::point_t data,
    output smf_pkg::coord_t      win_x [WINDOW],
    output smf_pkg::coord_t      win_y [WINDOW]
);

    smf_pkg::coord_t win_x_reg [WINDOW];
    smf_pkg::coord_t win_y_reg [WINDOW];

    // shift in the new point on each input transfer
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_x_reg[0] <= data.x_coord;
            win_y_reg[0] <= data.y_coord;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_x_reg[i] <= win_x_reg[i-1];
                win_y_reg[i] <= win_y_reg[i-1];
            end
        end
    end

    assign win_x = win_x_reg;
    assign win_y = win_y_reg;

endmodule
`default_nettype wire

// ===== src/smf_rank_unit.sv =====
// shared rank unit: stable rank of one candidate entry against the window, both axes
`default_nettype none
module smf_rank_unit #(
    parameter int WINDOW = smf_pkg::WINDOW_DEFAULT
) (
    input  wire smf_pkg::coord_t     win_x [WINDOW],
    input  wire smf_pkg::coord_t     win_y [WINDOW],
    input  wire logic [$clog2(WINDOW)-1:0] idx,
    output smf_pkg::rank_res_t       res
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int MEDIAN = WINDOW / 2;

    smf_pkg::coord_t  cand_x;
    smf_pkg::coord_t  cand_y;
    logic [CNT_W-1:0] rank_x;
    logic [CNT_W-1:0] rank_y;

    assign cand_x = win_x[idx];
    assign cand_y = win_y[idx];

    // count entries below the candidate; equal entries at lower index break ties
    always_comb
    begin
        rank_x = '0;
        rank_y = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if ((win_x[j] < cand_x) || ((win_x[j] == cand_x) && (IDX_W'(j) < idx)))
            begin
                rank_x = rank_x + CNT_W'(1);
            end
            if ((win_y[j] < cand_y) || ((win_y[j] == cand_y) && (IDX_W'(j) < idx)))
            begin
                rank_y = rank_y + CNT_W'(1);
            end
        end
    end

    assign res.hit_x  = (rank_x == CNT_W'(MEDIAN));
    assign res.hit_y  = (rank_y == CNT_W'(MEDIAN));
    assign res.cand_x = cand_x;
    assign res.cand_y = cand_y;

endmodule
`default_nettype wire

// ===== src/sliding_median_filter_2d_points_top.sv =====
// top level: sliding seven-point median filter over 2-D scan points
//
//  channel | signals                     | payload          | direction
//  --------+-----------------------------+------------------+----------
//  input   | in_valid, in_ready, in_data | smf_pkg::point_t | to block
//  output  | out_valid, out_ready, out_data | smf_pkg::result_t | from block
//
//  The first WINDOW-1 points only fill the window. Each later point is ranked
//  by the shared rank unit, one window entry per cycle, and the result then
//  waits in a hold state while the output register is full.
//  Reset clears the fill count, sequencer and output valid; no clearing pass.
//  Input is not ready while a window is being ranked or its result is held.
`default_nettype none
module sliding_median_filter_2d_points_top #(
    parameter int WINDOW = smf_pkg::WINDOW_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire smf_pkg::point_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output smf_pkg::result_t      out_data
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RANK = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    smf_pkg::coord_t    medx_reg, medx_next;
    smf_pkg::coord_t    medy_reg, medy_next;
    logic               out_valid_reg, out_valid_next;
    smf_pkg::result_t   out_data_reg, out_data_next;

    logic               in_xfer;
    logic               out_free;
    logic               last_idx;
    smf_pkg::coord_t    fin_x;
    smf_pkg::coord_t    fin_y;
    smf_pkg::coord_t    win_x [WINDOW];
    smf_pkg::coord_t    win_y [WINDOW];
    smf_pkg::rank_res_t rank;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_idx = (idx_reg == IDX_W'(WINDOW - 1));

    // window storage
    smf_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk      (clk),
        .shift_en (in_xfer),
        .data     (in_data),
        .win_x    (win_x),
        .win_y    (win_y)
    );

    // shared rank unit
    smf_rank_unit #(
        .WINDOW (WINDOW)
    ) u_rank (
        .win_x (win_x),
        .win_y (win_y),
        .idx   (idx_reg),
        .res   (rank)
    );

    // median as known at the end of the scan
    assign fin_x = rank.hit_x ? rank.cand_x : medx_reg;
    assign fin_y = rank.hit_y ? rank.cand_y : medy_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        medx_next      = medx_reg;
        medy_next      = medy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (fill_reg == FILL_W'(WINDOW - 1))
                    begin
                        state_next = S_RANK;
                        idx_next   = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_RANK:
            begin
                medx_next = fin_x;
                medy_next = fin_y;
                if (last_idx)
                begin
                    if (out_free)
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next.median_x = fin_x;
                        out_data_next.median_y = fin_y;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.median_x = medx_reg;
                    out_data_next.median_y = medy_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        medx_reg     <= medx_next;
        medy_reg     <= medy_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== src/smf_checker.sv =====
// port checker for the median filter top level, with its bind
`default_nettype none
module smf_checker #(
    parameter int WINDOW = smf_pkg::WINDOW_DEFAULT
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire smf_pkg::result_t out_data
);

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [CNT_W-1:0] in_cnt_reg;
    logic             in_xfer;
    logic             filling;

    assign in_xfer = in_valid && in_ready;
    assign filling = (in_cnt_reg < CNT_W'(WINDOW));

    // input transfers seen, saturating at WINDOW
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= '0;
        end
        else if (in_xfer && filling)
        begin
            in_cnt_reg <= in_cnt_reg + CNT_W'(1);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // no result before the window has filled
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        filling |-> !out_valid)
        else $error("result shown before the window is full");

    // a point that completes a full window starts ranking and blocks input
    a_rank_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_cnt_reg >= CNT_W'(WINDOW - 1)) |=> !in_ready)
        else $error("input ready while ranking a full window");

    // input stays ready while the window fills
    a_fill_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_cnt_reg < CNT_W'(WINDOW - 1)) |=> in_ready)
        else $error("input blocked while filling the window");

endmodule

bind sliding_median_filter_2d_points_top smf_checker #(
    .WINDOW (WINDOW)
) u_smf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb_sliding_median_filter_2d_points_top.sv =====
// testbench: seven-point sliding median filter checked against its own window predictor
`default_nettype none
module tb_sliding_median_filter_2d_points_top;

    localparam int WIN           = smf_pkg::WINDOW_DEFAULT;
    localparam int DIR_ROWS      = 23;
    localparam int PHASE_ITEMS   = 312;
    localparam int DRAIN_CYCLES  = 4 * (WIN + 1);
    localparam int MAX_REPORTS   = 10;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } chk_kind_t;

    typedef struct packed {
        smf_pkg::point_t  pt;
        chk_kind_t        kind;
        smf_pkg::result_t res;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    smf_pkg::point_t  in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    smf_pkg::result_t out_data;

    // predictor state: newest coordinate in entry 0
    smf_pkg::coord_t  win_x [WIN];
    smf_pkg::coord_t  win_y [WIN];
    int               points_seen = 0;

    smf_pkg::result_t expected_medians [$];
    dir_row_t         dir_table [DIR_ROWS];
    int               fault_count = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    sliding_median_filter_2d_points_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // watchdog
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // median of one axis: rank WIN/2 from the smallest, signed compare
    function automatic smf_pkg::coord_t window_median(input smf_pkg::coord_t w [WIN]);
        smf_pkg::coord_t s [WIN];
        smf_pkg::coord_t t;
        int              j;
        s = w;
        for (int i = 1; i < WIN; i++)
        begin
            t = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > t)
            begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = t;
        end
        return s[WIN / 2];
    endfunction

    // shift a point into the windows; returns 1 when the window is full with this point
    function automatic bit step_median_window(input smf_pkg::point_t p,
                                              output smf_pkg::result_t r);
        bit full;
        full = (points_seen >= WIN - 1);
        for (int i = WIN - 1; i > 0; i--)
        begin
            win_x[i] = win_x[i - 1];
            win_y[i] = win_y[i - 1];
        end
        win_x[0] = p.x_coord;
        win_y[0] = p.y_coord;
        r = '0;
        if (!full)
        begin
            points_seen++;
            return 1'b0;
        end
        r.median_x = window_median(win_x);
        r.median_y = window_median(win_y);
        return 1'b1;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // random coordinate biased toward ties, extremes and small values
    function automatic smf_pkg::coord_t rand_coord();
        case ($urandom_range(0, 9)) inside
            0:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            1:       return ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shffff;
            [2:3]:   return smf_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
            default: return smf_pkg::coord_t'($urandom);
        endcase
    endfunction

    // one input transfer with optional idle cycles ahead of it
    task automatic send_point(input smf_pkg::point_t p, input chk_kind_t kind,
                              input smf_pkg::result_t typed);
        smf_pkg::result_t r;
        bit               has_res;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_res = step_median_window(p, r);
        if (kind == CHK_TYPED)
            expected_medians = {expected_medians, typed};
        else if (kind == CHK_MODEL && has_res)
            expected_medians = {expected_medians, r};
    endtask

    // output side: random stalls and result checking
    always @(posedge clk)
    begin
        smf_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_medians.size() == 0)
            begin
                report_fault($sformatf("unexpected result x=%0d y=%0d",
                                       out_data.median_x, out_data.median_y));
            end
            else
            begin
                want = expected_medians.pop_front();
                if (out_data.median_x !== want.median_x
                    || out_data.median_y !== want.median_y)
                    report_fault($sformatf("expected x=%0d y=%0d, got x=%0d y=%0d",
                                           want.median_x, want.median_y,
                                           out_data.median_x, out_data.median_y));
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // stimulus
    initial
    begin
        int              idle_plan  [4];
        int              stall_plan [4];
        smf_pkg::point_t p;

        for (int i = 0; i < WIN; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
        end

        // fill rows, a readable first window, constant window, bit patterns
        dir_table = '{
            '{'{16'sh8000, 16'sh7fff}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'sh0000, 16'sh0000}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'sh0001, 16'shffff}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'shffff, 16'sh0001}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'sh0064, 16'shff9c}, CHK_NONE,  '{16'sh0000, 16'sh0000}},
            '{'{16'shff9c, 16'sh0064}, CHK_TYPED, '{16'sh0000, 16'sh0000}},
            '{'{16'sh8000, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7fff, 16'sh8000}, CHK_TYPED, '{16'sh7fff, 16'sh8000}},
            '{'{16'sh5555, 16'shaaaa}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'shaaaa, 16'sh5555}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh00ff, 16'shff00}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'shff00, 16'sh00ff}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'shfffe, 16'sh0002}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh0002, 16'shfffe}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh7ffe, 16'sh8001}, CHK_MODEL, '{16'sh0000, 16'sh0000}},
            '{'{16'sh8001, 16'sh7ffe}, CHK_MODEL, '{16'sh0000, 16'sh0000}}
        };
        idle_plan  = '{0, 65, 0, 14};
        stall_plan = '{0, 0, 65, 14};

        // reset
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        for (int i = 0; i < DIR_ROWS; i++)
            send_point(dir_table[i].pt, dir_table[i].kind, dir_table[i].res);

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p.x_coord = rand_coord();
                p.y_coord = rand_coord();
                send_point(p, CHK_MODEL, '0);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/smf_pkg.sv
src/smf_window.sv
src/smf_rank_unit.sv
src/sliding_median_filter_2d_points_top.sv
src/smf_checker.sv
tb/tb_sliding_median_filter_2d_points_top.sv
